/* sv/ptbl_pkg.sv */
// ---------------------------------------------------------------------------
// ptbl_pkg
// Shared types and constants of the prefix token bucket limiter.
// ---------------------------------------------------------------------------
package ptbl_pkg;

  localparam int COUNT_W   = 7;
  localparam int LANE_W    = 8;
  localparam int LANES     = 8;
  localparam int LANE_BITS = 3;
  localparam int WORD_W    = LANE_W * LANES;
  localparam int CFG_W     = 5;
  localparam int ADDR_W    = 32;

  localparam logic [COUNT_W-1:0] FULL_COUNT = 7'd127;
  localparam logic [CFG_W-1:0]   PFX_RESET  = 5'd16;
  localparam logic [CFG_W-1:0]   PFX_MIN    = 5'd3;

  typedef enum logic [0:0] {
    OP_ACQUIRE   = 1'b0,
    OP_REPLENISH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACQ,
    ST_SWEEP
  } state_t;

endpackage

/* sv/prefix_token_bucket_limiter.sv */
// ---------------------------------------------------------------------------
// prefix_token_bucket_limiter
// Per-prefix token buckets held in one RAM, eight 7-bit counters per word.
// ---------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 2**(MAX_PREFIX_BITS-3)
// words (8192 at the default) that fills every counter with 127; in_tready
// stays low until it ends. An acquire reads the RAM word, then decrements
// the counter and writes the word back once the result register is free,
// and returns one word. A replenish walks the RAM one word (eight counters)
// per cycle, read and write-back overlapped, with no result. One word is in
// work at a time; the result register lets the next word in while a result
// waits. Configuration writes are taken in any cycle.
// ---------------------------------------------------------------------------
module prefix_token_bucket_limiter
  import ptbl_pkg::*;
#(
  parameter int MAX_PREFIX_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [ADDR_W-1:0] in_tdata,   // [31:0] ip_address
  input  logic [0:0]        in_tuser,   // [0] operation
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [6:0] tokens_used, [7] zero
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data    // [4:0] prefix_bits
);

  localparam int AW    = MAX_PREFIX_BITS - LANE_BITS;
  localparam int WORDS = 2 ** AW;
  localparam logic [CFG_W-1:0] PfxMax = CFG_W'(MAX_PREFIX_BITS);

  state_t state_r, state_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic [LANE_BITS-1:0] lane_r, lane_nxt;
  logic [CFG_W-1:0]     prefix_r;
  logic                 out_valid_r;
  logic [COUNT_W-1:0]   out_data_r;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata;

  logic [CFG_W-1:0]           pfx_eff;
  logic [5:0]                 shamt;
  logic [ADDR_W-1:0]          shifted;
  logic [MAX_PREFIX_BITS-1:0] acq_idx;
  logic [COUNT_W-1:0]         old_cnt;
  logic [WORD_W-1:0]          acq_word, fill_word, refill_word;
  logic                       out_load;

  ptbl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    priority if (prefix_r < PFX_MIN) begin
      pfx_eff = PFX_MIN;
    end else if (prefix_r > PfxMax) begin
      pfx_eff = PfxMax;
    end else begin
      pfx_eff = prefix_r;
    end
    shamt   = 6'd32 - {1'b0, pfx_eff};
    shifted = in_tdata >> shamt;
    acq_idx = shifted[MAX_PREFIX_BITS-1:0];
  end

  always_comb begin
    logic [COUNT_W-1:0] c;
    logic [COUNT_W-1:0] cur;
    old_cnt     = '0;
    acq_word    = ram_rdata;
    fill_word   = '0;
    refill_word = '0;
    for (int l = 0; l < LANES; l++) begin
      if (LANE_BITS'(l) == lane_r) begin
        old_cnt = ram_rdata[l*LANE_W +: COUNT_W];
      end
    end
    for (int l = 0; l < LANES; l++) begin
      cur = ram_rdata[l*LANE_W +: COUNT_W];
      c   = (cur == FULL_COUNT) ? cur : cur + 7'd1;
      refill_word[l*LANE_W +: LANE_W] = {1'b0, c};
      fill_word[l*LANE_W +: LANE_W]   = {1'b0, FULL_COUNT};
      if (LANE_BITS'(l) == lane_r) begin
        acq_word[l*LANE_W +: LANE_W] =
          {1'b0, (old_cnt == '0) ? old_cnt : old_cnt - 7'd1};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    lane_nxt  = lane_r;
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = fill_word;
    ram_re    = 1'b0;
    ram_raddr = acq_idx[MAX_PREFIX_BITS-1:LANE_BITS];
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (ptr_r == '1) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          ram_re = 1'b1;
          if (in_tuser == OP_REPLENISH) begin
            ram_raddr = '0;
            ptr_nxt   = '0;
            state_nxt = ST_SWEEP;
          end else begin
            ptr_nxt   = acq_idx[MAX_PREFIX_BITS-1:LANE_BITS];
            lane_nxt  = acq_idx[LANE_BITS-1:0];
            state_nxt = ST_ACQ;
          end
        end
      end
      ST_ACQ: begin
        if (!out_valid_r || out_tready) begin
          ram_we    = 1'b1;
          ram_wdata = acq_word;
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_wdata = refill_word;
        if (ptr_r == '1) begin
          state_nxt = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_r + 1'b1;
          ptr_nxt   = ptr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ptr_r       <= '0;
      prefix_r    <= PFX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      if (cfg_valid) begin
        prefix_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    if (out_load) begin
      out_data_r <= FULL_COUNT - old_cnt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

endmodule

/* sv/ptbl_ram.sv */
// ---------------------------------------------------------------------------
// ptbl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ptbl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/ptbl_checker.sv */
// ---------------------------------------------------------------------------
// ptbl_checker
// Port-level checks of the prefix token bucket limiter, bound to the top.
// ---------------------------------------------------------------------------
module ptbl_checker
  import ptbl_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [0:0]        in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [7:0]        out_tdata
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("word accepted while previous one still in work");

  a_replenish_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == OP_REPLENISH) && !out_tvalid |=> !out_tvalid)
    else $error("replenish produced a result");

  a_acquire_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == OP_ACQUIRE) && !out_tvalid |=> !out_tvalid ##1 out_tvalid)
    else $error("acquire result not delivered after read-modify-write");

endmodule

bind prefix_token_bucket_limiter ptbl_checker u_ptbl_checker (.*);

/* tb/prefix_token_bucket_limiter_tb.sv */
// ---------------------------------------------------------------------------
// prefix_token_bucket_limiter_tb
// Self-checking bench for the prefix token bucket limiter. A bucket-table
// model predicts tokens_used for every accepted acquire and refills the whole
// table on every accepted replenish. Directed tests cover address extremes,
// prefix width clamping, width changes, refill reach and back-pressure; random
// phases follow at several prefix widths with hot buckets that drain to empty.
// ---------------------------------------------------------------------------
module prefix_token_bucket_limiter_tb;
  import ptbl_pkg::*;

  localparam int MAX_PFX     = 16;
  localparam int DEPTH       = 1 << MAX_PFX;
  localparam int SWEEP_WAIT  = (1 << (MAX_PFX - 3)) + 16;
  localparam int LIMIT       = 4000000;
  localparam int PHASE_WORDS = 255;
  localparam int REFILL_CAP  = 45;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [ADDR_W-1:0] in_tdata;   // [31:0] ip_address
  logic [0:0]        in_tuser;   // [0] operation
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;  // [6:0] tokens_used, [7] zero
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data;   // [4:0] prefix_bits

  prefix_token_bucket_limiter #(.MAX_PREFIX_BITS(MAX_PFX)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // bucket model
  logic [COUNT_W-1:0] bucket_level [DEPTH];
  logic [CFG_W-1:0]   pfx_reg;
  logic [COUNT_W-1:0] used_q [$];

  bit sweep_open;
  bit rush;
  int hold_req;
  int faults;
  int acq_cnt, refill_cnt, denied_cnt, cfg_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int eff_width();
    int p;
    p = pfx_reg;
    if (p < PFX_MIN) p = PFX_MIN;
    if (p > MAX_PFX) p = MAX_PFX;
    return p;
  endfunction

  function automatic logic [COUNT_W-1:0] take_token(input logic [ADDR_W-1:0] addr);
    int idx;
    logic [COUNT_W-1:0] lvl;
    idx = (addr >> (ADDR_W - eff_width())) & (DEPTH - 1);
    lvl = bucket_level[idx];
    if (lvl != 0) bucket_level[idx] = lvl - 1'b1;
    return FULL_COUNT - lvl;
  endfunction

  function automatic void refill_all();
    for (int k = 0; k < DEPTH; k++) begin
      if (bucket_level[k] < FULL_COUNT) bucket_level[k] = bucket_level[k] + 1'b1;
    end
  endfunction

  task automatic note_fault(input string what, input logic [7:0] want, input logic [7:0] got);
    faults++;
    if (faults <= 10)
      $display("[%0t] %s: expected tokens_used %0d, got %0d", $realtime, what, want, got);
  endtask

  task automatic send_word(input op_t op, input logic [ADDR_W-1:0] addr);
    int gap;
    logic [COUNT_W-1:0] used;
    gap = rush ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    if (op == OP_ACQUIRE) begin
      used = take_token(addr);
      used_q.push_back(used);
      acq_cnt++;
      if (used == FULL_COUNT) denied_cnt++;
    end else begin
      refill_all();
      refill_cnt++;
      sweep_open = 1'b1;
    end
  endtask

  // wait out all results, plus a full sweep if a replenish may still run
  task automatic settle();
    in_tvalid <= 1'b0;
    while (used_q.size() != 0) @(posedge clk);
    repeat (sweep_open ? SWEEP_WAIT : 4) @(posedge clk);
    sweep_open = 1'b0;
  endtask

  task automatic write_prefix(input logic [CFG_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pfx_reg = value;
    cfg_cnt++;
  endtask

  task automatic test_default_width();
    send_word(OP_ACQUIRE, 32'h0000_0000);
    send_word(OP_ACQUIRE, 32'hFFFF_FFFF);
    send_word(OP_ACQUIRE, 32'h0000_FFFF);
    send_word(OP_ACQUIRE, 32'hFFFF_0000);
    send_word(OP_ACQUIRE, 32'h1234_5678);
  endtask

  task automatic test_width_clamp();
    write_prefix(5'd0);
    send_word(OP_ACQUIRE, 32'hA000_0000);
    write_prefix(5'd2);
    send_word(OP_ACQUIRE, 32'hA5A5_5A5A);
    write_prefix(5'd17);
    send_word(OP_ACQUIRE, 32'hA5A5_FFFF);
    write_prefix(5'd31);
    send_word(OP_ACQUIRE, 32'hFFFF_1234);
  endtask

  // counters survive a width change and get reindexed
  task automatic test_width_change();
    write_prefix(5'd3);
    send_word(OP_ACQUIRE, 32'hE000_0000);
    send_word(OP_ACQUIRE, 32'hFFFF_FFFF);
    write_prefix(5'd16);
    send_word(OP_ACQUIRE, 32'h0007_1234);
  endtask

  // refill walks the whole table, even buckets the current width misses
  task automatic test_replenish();
    send_word(OP_REPLENISH, 32'hDEAD_BEEF);
    send_word(OP_ACQUIRE, 32'h0007_0000);
    write_prefix(5'd3);
    send_word(OP_REPLENISH, 32'h0000_0000);
    send_word(OP_REPLENISH, 32'hFFFF_FFFF);
    write_prefix(5'd16);
    send_word(OP_ACQUIRE, 32'hFFFF_0000);
    send_word(OP_ACQUIRE, 32'h1234_0000);
  endtask

  task automatic test_backpressure();
    logic [ADDR_W-1:0] hot;
    write_prefix(5'd8);
    hot = $urandom;
    rush = 1'b1;
    hold_req = 300;
    for (int i = 0; i < 24; i++)
      send_word(OP_ACQUIRE, {hot[31:24], 24'($urandom)});
    rush = 1'b0;
  endtask

  task automatic run_random_phase(input logic [CFG_W-1:0] width, input int words);
    logic [ADDR_W-1:0] hot0, hot1, low_mask, addr;
    int pick;
    op_t op;
    write_prefix(width);
    hot0 = $urandom;
    hot1 = $urandom;
    low_mask = 32'hFFFF_FFFF >> eff_width();
    for (int i = 0; i < words; i++) begin
      if (i % 64 == 0) rush = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 60) addr = (hot0 & ~low_mask) | ($urandom & low_mask);
      else if (pick < 85) addr = (hot1 & ~low_mask) | ($urandom & low_mask);
      else addr = $urandom;
      op = OP_ACQUIRE;
      if (refill_cnt < REFILL_CAP && $urandom_range(0, 47) == 0) op = OP_REPLENISH;
      send_word(op, addr);
    end
    rush = 1'b0;
  endtask

  // result checker and out_tready pacing
  initial begin : result_check
    int wait_cnt;
    logic [7:0] want;
    wait_cnt = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready) begin
        if (used_q.size() == 0) begin
          note_fault("unexpected word", 8'h00, out_tdata);
        end else begin
          want = {1'b0, used_q.pop_front()};
          if (out_tdata !== want) note_fault("mismatch", want, out_tdata);
        end
        wait_cnt = rush ? 0 : $urandom_range(0, 6);
      end
      if (hold_req > 0) begin
        wait_cnt = hold_req;
        hold_req = 0;
      end
      if (wait_cnt > 0) begin
        out_tready <= 1'b0;
        wait_cnt--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d words outstanding", cycles, used_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_ACQUIRE;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    for (int k = 0; k < DEPTH; k++) bucket_level[k] = FULL_COUNT;
    pfx_reg = PFX_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_width();
    test_width_clamp();
    test_width_change();
    test_replenish();
    test_backpressure();
    run_random_phase(5'd3, PHASE_WORDS);
    run_random_phase(5'd16, PHASE_WORDS);
    run_random_phase(5'd0, PHASE_WORDS);
    run_random_phase(5'd31, PHASE_WORDS);
    run_random_phase(5'($urandom_range(4, 15)), PHASE_WORDS);
    run_random_phase(5'($urandom_range(0, 31)), PHASE_WORDS);
    settle();

    $display("covered %0d acquires (%0d denied), %0d replenishes, %0d prefix writes",
             acq_cnt, denied_cnt, refill_cnt, cfg_cnt);
    $display("widths 0..31 incl. clamped ones, long output stall, %0d faults", faults);
    if (faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
